// ===== rtl/core/ctw_pkg.sv =====
`default_nettype none

package ctw_pkg;

  // Action codes carried in the input tuser.
  localparam logic [1:0] ACT_RESEED = 2'd0;
  localparam logic [1:0] ACT_FRAC   = 2'd1;
  localparam logic [1:0] ACT_RANGE  = 2'd2;

  // Number of generator advances after a reseed.
  localparam int WARMUP_STEPS = 10;
  localparam int WARM_W       = 4;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int FRAC_W = 52;
  localparam int HALF_W = FRAC_W / 2;
  localparam int SPAN_W = 33;
  localparam int PROD_W = HALF_W + SPAN_W;

  // Minimum exponents of the four components, one byte each, lowest first.
  localparam logic [31:0] SEED_MINIMA = 32'h11090601;

  typedef logic [3:0][63:0] comp_words_t;

  localparam comp_words_t SEED_RESETS = {
    64'h00000000CC0000CC, 64'h00000000FF0000FF,
    64'h00000000CCCCCCCC, 64'h00000000FFFFFFFF
  };

  typedef enum logic [1:0] {
    KIND_RESEED = 2'd0,
    KIND_FRAC   = 2'd1,
    KIND_RANGE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // One classified transaction waiting in the queue.
  typedef struct packed {
    kind_t                     kind;
    logic [31:0]               range_low;
    logic [SPAN_W-1:0]         span;
    logic                      err;
  } queue_entry_t;

  // One item leaving the generator for the scaling pipeline.
  typedef struct packed {
    logic [FRAC_W-1:0]         frac;
    logic [31:0]               range_low;
    logic [SPAN_W-1:0]         span;
    logic                      err;
  } work_t;

  // One step of a Tausworthe component with parameters (k, q, s).
  function automatic logic [63:0] tw_step(input logic [63:0] z, input int k,
                                          input int q, input int s);
    logic [63:0] keep;
    begin
      keep = ~64'd0 << (64 - k);
      return (((z << q) ^ z) >> (k - s)) ^ ((z & keep) << s);
    end
  endfunction

  // Advance all four components once.
  function automatic comp_words_t advance(input comp_words_t c);
    comp_words_t n;
    begin
      n[0] = tw_step(c[0], 63, 31, 18);
      n[1] = tw_step(c[1], 58, 19, 28);
      n[2] = tw_step(c[2], 55, 24, 7);
      n[3] = tw_step(c[3], 47, 21, 8);
      return n;
    end
  endfunction

  // Lift a seed word that lies below its component's minimum.
  function automatic logic [63:0] seed_lift(input logic [63:0] w, input int i);
    logic [63:0] m;
    begin
      m = 64'd1 << SEED_MINIMA[8*i +: 5];
      return (w < m) ? w + m : w;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ctw_front.sv =====
`default_nettype none

module ctw_front (
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [63:0]           s_tdata,  // range_low [31:0], range_high [63:32]
  input  wire logic [1:0]            s_tuser,  // action [1:0]
  input  wire logic                  full,
  output logic                       push,
  output ctw_pkg::queue_entry_t      push_entry
);
  import ctw_pkg::*;

  logic signed [32:0] diff;
  logic [31:0]        lo;
  logic [31:0]        hi;

  assign lo = s_tdata[31:0];
  assign hi = s_tdata[63:32];

  // Accept whenever the queue has room.
  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // Range width minus one, exact in 33 bits; negative means an inverted range.
  assign diff = $signed({hi[31], hi}) - $signed({lo[31], lo});

  // Classify the transaction and prepare the range operands.
  always_comb begin
    push_entry.kind      = KIND_NONE;
    push_entry.range_low = '0;
    push_entry.span      = '0;
    push_entry.err       = 1'b0;
    case (s_tuser)
      ACT_RESEED: begin
        push_entry.kind = KIND_RESEED;
      end
      ACT_FRAC: begin
        push_entry.kind = KIND_FRAC;
      end
      ACT_RANGE: begin
        push_entry.kind      = KIND_RANGE;
        push_entry.range_low = lo;
        push_entry.err       = diff[32];
        // An inverted range scales by zero, which leaves range_low.
        push_entry.span      = diff[32] ? '0 : SPAN_W'(diff) + SPAN_W'(1);
      end
      default: begin
        push_entry.kind = KIND_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctw_queue.sv =====
`default_nettype none

module ctw_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ctw_pkg::queue_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output ctw_pkg::queue_entry_t      head
);
  import ctw_pkg::*;

  queue_entry_t      slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctw_gen.sv =====
`default_nettype none

module ctw_gen (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic                  head_valid,
  input  wire ctw_pkg::queue_entry_t head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ctw_pkg::work_t             out_item
);
  import ctw_pkg::*;

  comp_words_t       seed;
  comp_words_t       comp;
  comp_words_t       comp_adv;
  comp_words_t       lifted;
  logic              busy;
  logic [WARM_W-1:0] warm_count;
  logic [63:0]       mix;
  work_t             item_next;

  // Next component words and the combined output word.
  assign comp_adv = advance(comp);
  assign mix      = comp_adv[0] ^ comp_adv[1] ^ comp_adv[2] ^ comp_adv[3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lifted[i] = seed_lift(seed[i], i);
    end
  end

  // Take the next transaction when not warming up and the slot frees.
  assign pop = head_valid && !busy && (!out_valid || out_ready);

  always_comb begin
    item_next.range_low = head.range_low;
    item_next.span      = head.span;
    item_next.err       = head.err;
    if (head.kind == KIND_FRAC || head.kind == KIND_RANGE) begin
      item_next.frac = mix[FRAC_W-1:0];
    end else begin
      item_next.frac = '0;
    end
  end

  // Seed registers, generator state and the warm-up sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= SEED_RESETS;
      comp       <= SEED_RESETS;
      busy       <= 1'b0;
      warm_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed[cfg_index] <= cfg_data;
      end
      if (busy) begin
        comp       <= comp_adv;
        warm_count <= warm_count + 1'b1;
        if (warm_count == WARM_W'(WARMUP_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end else if (pop) begin
        case (head.kind)
          KIND_RESEED: begin
            comp       <= lifted;
            warm_count <= '0;
            busy       <= (WARMUP_STEPS != 0);
          end
          KIND_FRAC, KIND_RANGE: begin
            comp <= comp_adv;
          end
          default: begin
            comp <= comp;
          end
        endcase
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item handed to the scaling pipeline.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= item_next;
    end
  end

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop)
    else $error("transaction taken during warm-up");

  a_reseed_starts_warmup: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == KIND_RESEED) |=> (busy || WARMUP_STEPS == 0))
    else $error("reseed did not start warm-up");

  a_warm_count_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (warm_count < WARM_W'(WARMUP_STEPS)))
    else $error("warm-up count out of range");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled item changed");

endmodule

`default_nettype wire

// ===== rtl/core/ctw_scale.sv =====
`default_nettype none

module ctw_scale (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ctw_pkg::work_t        in_item,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [87:0]                m_tdata,  // fraction [51:0], ranged_value [83:52]
  output logic                       m_tuser   // range_error [0]
);
  import ctw_pkg::*;

  logic                      mul_valid;
  logic                      mul_ready;
  logic [PROD_W-1:0]         prod_hi;
  logic [PROD_W-1:0]         prod_lo;
  logic [FRAC_W-1:0]         mul_frac;
  logic [31:0]               mul_low;
  logic                      mul_err;
  logic                      out_ready;
  logic [PROD_W:0]           prod_sum;
  logic [FRAC_W-1:0]         out_frac;
  logic [31:0]               out_value;
  logic                      out_err;

  assign out_ready = !m_tvalid || m_tready;
  assign mul_ready = !mul_valid || out_ready;
  assign in_ready  = mul_ready;

  // Exact floor(frac * span / 2^52) from two half-width products.
  assign prod_sum = (PROD_W+1)'(prod_hi) + (PROD_W+1)'(prod_lo >> HALF_W);

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && in_valid) begin
      prod_hi  <= PROD_W'(in_item.frac[FRAC_W-1:HALF_W]) * PROD_W'(in_item.span);
      prod_lo  <= PROD_W'(in_item.frac[HALF_W-1:0]) * PROD_W'(in_item.span);
      mul_frac <= in_item.frac;
      mul_low  <= in_item.range_low;
      mul_err  <= in_item.err;
    end
  end

  // Output register: add the range base to the scaled value.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mul_valid) begin
      out_frac  <= mul_frac;
      out_value <= mul_low + prod_sum[HALF_W +: 32];
      out_err   <= mul_err;
    end
  end

  assign m_tdata = {4'b0, out_value, out_frac};
  assign m_tuser = out_err;

endmodule

`default_nettype wire

// ===== rtl/core/combined_tausworthe_random.sv =====
// A draw passes the queue, the generator output register, the multiply stage and the output register to m_tvalid.
// Throughput: one draw per cycle while no warm-up runs and m_tready does not stall, one component advance per draw.
// A reseed sends its zero result down the pipeline like any other draw, then holds
// the generator for 10 warm-up advances before the next queued transaction.
// Reset loads the seed registers and components with their reset words, no warm-up.
`default_nettype none

module combined_tausworthe_random (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // range_low [31:0], range_high [63:32]
  input  wire logic [1:0]  s_tuser,   // action [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,   // fraction [51:0], ranged_value [83:52]
  output logic             m_tuser    // range_error [0]
);
  import ctw_pkg::*;

  logic         full;
  logic         push;
  queue_entry_t push_entry;
  logic         pop;
  logic         head_valid;
  queue_entry_t head;
  logic         work_valid;
  logic         work_ready;
  work_t        work_item;

  ctw_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  ctw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ctw_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (work_valid),
    .out_ready  (work_ready),
    .out_item   (work_item)
  );

  ctw_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (work_valid),
    .in_ready (work_ready),
    .in_item  (work_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
